// ----- rtl/iqs_pkg.sv -----
package iqs_pkg;

    // Queue geometry.
    localparam int DEPTH  = 16;
    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    // Fixed field widths on the stream ports.
    localparam int OP_W   = 3;
    localparam int VAL_W  = 64;
    localparam int POS_W  = 6;
    localparam int OCC_W  = 5;

    // Width wide enough to compare a count against a position magnitude.
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_BITS     = VAL_W + POS_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + VAL_W + 1 + OCC_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_POP_AT   = 3'd2,
        OP_PUSH_AT  = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_REVERSE  = 3'd5,
        OP_CLEAR    = 3'd6
    } t_opcode;

    typedef struct packed {
        logic              done_ok;
        logic [VAL_W-1:0]  value_out;
        logic              found;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } t_result;

endpackage

// ----- rtl/indexed_queue_store_unit.sv -----
// Channel   Dir  Transfer on            Contents
// s_axis    in   tvalid & tready        tuser: opcode; tdata: value_in, position
// m_axis    out  tvalid & tready        tdata: done_ok, value_out, found, occupancy, is_empty
//
// One operation per cycle is sustained while results are taken; each result passes
// through the input register, then the result register.
// Each operation is resolved combinationally by the parallel cell row in iqs_store.
// Reset is synchronous and empties the queue; cell contents are not cleared.
// A stalled result holds the result register, and the input register then
// holds its item, so the input side stalls one item later.
module indexed_queue_store_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [63:0] value_in, [69:64] position, [71:70] zero
    input  logic [iqs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [2:0] opcode
    input  logic [iqs_pkg::OP_W-1:0]           i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] done_ok, [64:1] value_out, [65] found, [70:66] occupancy, [71] is_empty
    output logic [iqs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import iqs_pkg::*;

    logic              r_in_valid;
    t_opcode           r_in_op;
    logic [VAL_W-1:0]  r_in_value;
    logic [POS_W-1:0]  r_in_position;
    logic              r_out_valid;
    t_result           r_result;
    t_result           exec_result;
    logic              in_fire;
    logic              exec;

    // Handshake: execute when the result register is free or draining.
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign exec            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || exec;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_op       <= t_opcode'(i_s_axis_tuser);
            r_in_value    <= i_s_axis_tdata[VAL_W-1:0];
            r_in_position <= i_s_axis_tdata[VAL_W +: POS_W];
        end
    end

    // Queue state and operation logic.
    iqs_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_exec     (exec),
        .i_op       (r_in_op),
        .i_value    (r_in_value),
        .i_position (r_in_position),
        .o_result   (exec_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_result <= exec_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_result.is_empty, r_result.occupancy,
                                           r_result.found, r_result.value_out,
                                           r_result.done_ok});

    // The reported occupancy never exceeds the queue depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy beyond queue depth");

    // The empty flag agrees with the occupancy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.is_empty == (r_result.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    // A failed operation never returns a value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.done_ok) |-> (r_result.value_out == '0))
        else $error("value returned by a failed operation");

    // An item held back by a stalled result is kept unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !exec) |=> (r_in_valid && $stable(r_in_value)
                                   && $stable(r_in_position)))
        else $error("held input item changed");

endmodule

// ----- rtl/iqs_store.sv -----
module iqs_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_exec,
    input  iqs_pkg::t_opcode              i_op,
    input  logic [iqs_pkg::VAL_W-1:0]     i_value,
    input  logic [iqs_pkg::POS_W-1:0]     i_position,
    output iqs_pkg::t_result              o_result
);
    import iqs_pkg::*;

    logic [DATA_W-1:0] r_cells [DEPTH];
    logic [DATA_W-1:0] n_cells [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic [DATA_W-1:0] v;
    logic              neg;
    logic [POS_W-1:0]  pmag;
    logic [CMP_W-1:0]  pmag_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              full;
    logic              empty;
    logic              rm_at_ok;
    logic [CMP_W-1:0]  rm_at_idx_x;
    logic              ins_at_ok;
    logic [CMP_W-1:0]  ins_at_idx_x;
    logic              do_rm;
    logic              do_ins;
    logic              do_rev;
    logic              do_clr;
    logic              is_contains;
    logic              ok;
    logic [CMP_W-1:0]  idx_x;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] rd_val;
    logic              match;

    // Position decode: magnitude and the resulting head-relative index.
    always_comb begin
        v            = i_value[DATA_W-1:0];
        neg          = i_position[POS_W-1];
        pmag         = neg ? (~i_position + POS_W'(1)) : i_position;
        pmag_x       = CMP_W'(pmag);
        cnt_x        = CMP_W'(r_count);
        full         = cnt_x >= CMP_W'(DEPTH);
        empty        = (r_count == '0);
        rm_at_ok     = pmag_x < cnt_x;
        rm_at_idx_x  = neg ? (cnt_x - CMP_W'(1) - pmag_x) : pmag_x;
        ins_at_ok    = !full && (pmag_x <= cnt_x);
        if (pmag == '0) begin
            ins_at_idx_x = cnt_x;
        end else if (neg) begin
            ins_at_idx_x = cnt_x - pmag_x;
        end else begin
            ins_at_idx_x = pmag_x;
        end
    end

    // Operation decode.
    always_comb begin
        do_rm       = 1'b0;
        do_ins      = 1'b0;
        do_rev      = 1'b0;
        do_clr      = 1'b0;
        is_contains = 1'b0;
        ok          = 1'b0;
        idx_x       = '0;
        unique case (i_op)
            OP_PUSH: begin
                do_ins = !full;
                ok     = !full;
                idx_x  = cnt_x;
            end
            OP_POP: begin
                do_rm = !empty;
                ok    = !empty;
            end
            OP_POP_AT: begin
                do_rm = rm_at_ok;
                ok    = rm_at_ok;
                idx_x = rm_at_idx_x;
            end
            OP_PUSH_AT: begin
                do_ins = ins_at_ok;
                ok     = ins_at_ok;
                idx_x  = ins_at_idx_x;
            end
            OP_CONTAINS: begin
                is_contains = 1'b1;
                ok          = 1'b1;
            end
            OP_REVERSE: begin
                do_rev = 1'b1;
                ok     = 1'b1;
            end
            OP_CLEAR: begin
                do_clr = 1'b1;
                ok     = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        idx = idx_x[IDX_W-1:0];
    end

    // Every cell picks its next value from itself, a neighbour, its mirror cell on reverse, or the input on insert.
    always_comb begin
        rd_val = r_cells[idx];
        match  = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            n_cells[i] = r_cells[i];
            if (do_rm && (IDX_W'(i) >= idx)) begin
                n_cells[i] = r_cells[(i + 1 < DEPTH) ? i + 1 : i];
            end
            if (do_ins) begin
                if (IDX_W'(i) == idx) begin
                    n_cells[i] = v;
                end else if (IDX_W'(i) > idx) begin
                    n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                end
            end
            if (do_rev && (CNT_W'(i) < r_count)) begin
                n_cells[i] = r_cells[IDX_W'(r_count - CNT_W'(1) - CNT_W'(i))];
            end
            if ((CNT_W'(i) < r_count) && (r_cells[i] == v)) begin
                match = 1'b1;
            end
        end
    end

    // Entry count and result.
    always_comb begin
        n_count = r_count;
        if (do_rm) begin
            n_count = r_count - CNT_W'(1);
        end else if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_clr) begin
            n_count = '0;
        end
        o_result.done_ok   = ok;
        o_result.value_out = do_rm ? VAL_W'(rd_val) : '0;
        o_result.found     = is_contains && match;
        o_result.occupancy = OCC_W'(n_count);
        o_result.is_empty  = (n_count == '0);
    end

    // Cell contents carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            r_cells <= n_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_exec) begin
            r_count <= n_count;
        end
    end

endmodule

// ----- tb/sv/indexed_queue_store_unit_tb.sv -----
module indexed_queue_store_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import iqs_pkg::*;

    localparam int                CLK_HALF       = 10;
    localparam int                RESET_CYCLES   = 7;
    localparam int                RANDOM_OPS     = 950;
    localparam int                PHASE_LEN      = 64;
    localparam int                MAX_WAIT       = 16;
    localparam int                STALL_LIMIT    = 2000;
    localparam int                DRAIN_CYCLES   = 8;
    localparam logic [OP_W-1:0]   OP_UNUSED      = 3'd7;

    // One row of the directed table; fixed_res is only used when has_fixed is set.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             has_fixed;
        t_result          fixed_res;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [63:0] value_in, [69:64] position, [71:70] zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // [2:0] opcode
    logic [OP_W-1:0]        i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [0] done_ok, [64:1] value_out, [65] found, [70:66] occupancy, [71] is_empty
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Shadow copy of the queue contents, head at index 0.
    logic [VAL_W-1:0] queue_entries[$];
    t_result          awaited_results[$];
    t_stim_row        directed_ops[$];
    int               mismatches = 0;
    int               idle_cycles = 0;
    bit               send_burst = 1'b0;
    bit               recv_burst = 1'b0;

    indexed_queue_store_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Applies one operation to the shadow queue and returns the result it gives.
    function automatic t_result queue_op_outcome(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                                 logic [POS_W-1:0] pos);
        t_result          res;
        int               p;
        int               n;
        int               idx;
        bit               valid;
        logic [VAL_W-1:0] saved[$];
        res   = '0;
        p     = $signed(pos);
        n     = queue_entries.size();
        idx   = 0;
        valid = 1'b0;
        case (op)
            OP_PUSH: begin
                if (n < DEPTH) begin
                    queue_entries.push_back(value);
                    res.done_ok = 1'b1;
                end
            end
            OP_POP: begin
                if (n > 0) begin
                    res.value_out = queue_entries.pop_front();
                    res.done_ok   = 1'b1;
                end
            end
            OP_POP_AT: begin
                if (p >= 0 && p < n) begin
                    idx   = p;
                    valid = 1'b1;
                end else if (p < 0 && -p < n) begin
                    idx   = n - 1 + p;
                    valid = 1'b1;
                end
                if (valid) begin
                    res.value_out = queue_entries[idx];
                    queue_entries.delete(idx);
                    res.done_ok   = 1'b1;
                end
            end
            OP_PUSH_AT: begin
                // Position zero appends; a negative position counts back from the tail.
                if (p >= 0 && p <= n) begin
                    idx   = (p == 0) ? n : p;
                    valid = (n < DEPTH);
                end else if (p < 0 && -p <= n) begin
                    idx   = n + p;
                    valid = (n < DEPTH);
                end
                if (valid) begin
                    if (idx == n) begin
                        queue_entries.push_back(value);
                    end else begin
                        queue_entries.insert(idx, value);
                    end
                    res.done_ok = 1'b1;
                end
            end
            OP_CONTAINS: begin
                foreach (queue_entries[i]) begin
                    if (queue_entries[i] == value) begin
                        res.found = 1'b1;
                    end
                end
                res.done_ok = 1'b1;
            end
            OP_REVERSE: begin
                saved = queue_entries;
                queue_entries.delete();
                foreach (saved[i]) begin
                    queue_entries.push_front(saved[i]);
                end
                res.done_ok = 1'b1;
            end
            OP_CLEAR: begin
                queue_entries.delete();
                res.done_ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(queue_entries.size());
        res.is_empty  = (queue_entries.size() == 0);
        return res;
    endfunction

    // A failed or plain result whose value and found flag are both zero.
    function automatic t_result plain_result(logic ok, int occ);
        t_result res;
        res           = '0;
        res.done_ok   = ok;
        res.occupancy = OCC_W'(occ);
        res.is_empty  = (occ == 0);
        return res;
    endfunction

    task automatic add_row(logic [OP_W-1:0] op, logic [VAL_W-1:0] value, int pos,
                           bit has_fixed, logic ok, int occ);
        t_stim_row row;
        row.op        = op;
        row.value     = value;
        row.pos       = POS_W'(pos);
        row.has_fixed = has_fixed;
        row.fixed_res = plain_result(ok, occ);
        directed_ops.push_back(row);
    endtask

    // Presents one operation after a random gap and waits for its transfer.
    task automatic send_op(t_stim_row row);
        int      gap;
        t_result predicted;
        if ($urandom_range(0, 31) == 0) begin
            send_burst = ~send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = row.op;
        i_s_axis_tdata  = {2'b00, row.pos, row.value};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predicted = queue_op_outcome(row.op, row.value, row.pos);
        awaited_results.push_back(row.has_fixed ? row.fixed_res : predicted);
        @(negedge i_clk);
    endtask

    task automatic report_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Result side: random stalls, and every transfer is checked against the oldest expectation.
    initial begin
        int      stall;
        t_result exp_res;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                recv_burst = ~recv_burst;
            end
            stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) begin
                @(posedge i_clk);
            end
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with none expected, actual %0h", $time,
                         o_m_axis_tdata);
            end else begin
                exp_res = awaited_results.pop_front();
                report_field("done_ok",   VAL_W'(exp_res.done_ok),   VAL_W'(o_m_axis_tdata[0]));
                report_field("value_out", exp_res.value_out,         o_m_axis_tdata[64:1]);
                report_field("found",     VAL_W'(exp_res.found),     VAL_W'(o_m_axis_tdata[65]));
                report_field("occupancy", VAL_W'(exp_res.occupancy),
                             VAL_W'(o_m_axis_tdata[70:66]));
                report_field("is_empty",  VAL_W'(exp_res.is_empty),  VAL_W'(o_m_axis_tdata[71]));
            end
            @(negedge i_clk);
        end
    end

    // Watchdog: too many cycles without a transfer on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: directed table first, then phased random operations.
    initial begin
        t_stim_row row;
        int        n;
        int        r;
        int        phase;
        int        pos_sel;
        bit        grow;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty queue: removals fail, search and reverse succeed with nothing found; then two pushes.
        add_row(OP_POP,      '0,                    0,   1, 1'b0, 0);
        add_row(OP_POP_AT,   '0,                    0,   1, 1'b0, 0);
        add_row(OP_CONTAINS, '0,                    0,   1, 1'b1, 0);
        add_row(OP_REVERSE,  '0,                    0,   1, 1'b1, 0);
        add_row(OP_PUSH,     '1,                    0,   1, 1'b1, 1);
        add_row(OP_PUSH,     '0,                    0,   1, 1'b1, 2);
        // Insert at the tail, at the end by count, at the head by a negative count; out-of-range inserts fail.
        add_row(OP_PUSH_AT,  64'hA5A5_A5A5_A5A5_A5A5, 0,   0, 1'b0, 0);
        add_row(OP_PUSH_AT,  64'h0123_4567_89AB_CDEF, 3,   0, 1'b0, 0);
        add_row(OP_PUSH_AT,  64'h8000_0000_0000_0001, -4,  0, 1'b0, 0);
        add_row(OP_PUSH_AT,  64'h1,                 6,   1, 1'b0, 5);
        add_row(OP_PUSH_AT,  64'h2,                 -16, 1, 1'b0, 5);
        add_row(OP_PUSH_AT,  64'h7FFF_FFFF_FFFF_FFFF, 1,   0, 1'b0, 0);
        add_row(OP_PUSH_AT,  64'h5A,                -1,  0, 1'b0, 0);
        add_row(OP_CONTAINS, '1,                    0,   0, 1'b0, 0);
        add_row(OP_CONTAINS, 64'h1234,              0,   0, 1'b0, 0);
        add_row(OP_REVERSE,  '0,                    0,   0, 1'b0, 0);
        add_row(OP_POP_AT,   '0,                    -1,  0, 1'b0, 0);
        // Positions at the limits of the field and the unused opcode.
        add_row(OP_POP_AT,   '0,                    31,  1, 1'b0, 6);
        add_row(OP_POP_AT,   '0,                    -32, 1, 1'b0, 6);
        add_row(OP_UNUSED,   '1,                    -1,  1, 1'b0, 6);
        add_row(OP_POP,      '0,                    0,   0, 1'b0, 0);
        add_row(OP_POP_AT,   '0,                    2,   0, 1'b0, 0);
        add_row(OP_POP_AT,   '0,                    -4,  1, 1'b0, 4);
        add_row(OP_PUSH_AT,  64'h3,                 16,  1, 1'b0, 4);
        add_row(OP_CLEAR,    '0,                    0,   1, 1'b1, 0);
        add_row(OP_POP,      '0,                    0,   1, 1'b0, 0);
        foreach (directed_ops[i]) begin
            send_op(directed_ops[i]);
        end

        // Random part: phases that favour filling, draining, or neither.
        for (int k = 0; k < RANDOM_OPS; k++) begin
            n     = queue_entries.size();
            phase = (k / PHASE_LEN) % 3;
            r     = $urandom_range(0, 99);
            row   = '0;
            if (r < 2) begin
                row.op = OP_UNUSED;
            end else if (r < 3) begin
                row.op = OP_CLEAR;
            end else if (r < 11) begin
                row.op = OP_CONTAINS;
            end else if (r < 16) begin
                row.op = OP_REVERSE;
            end else begin
                grow   = (phase == 0) ? (r < 88) : ((phase == 1) ? (r < 32) : (r < 58));
                row.op = grow ? ($urandom_range(0, 1) ? OP_PUSH : OP_PUSH_AT)
                              : ($urandom_range(0, 1) ? OP_POP : OP_POP_AT);
            end
            // Values: stored entries for search hits, extremes, small and wide values.
            case ($urandom_range(0, 7))
                0: row.value = (n > 0) ? queue_entries[$urandom_range(0, n - 1)] : '0;
                1: row.value = '1;
                2: row.value = '0;
                3: row.value = VAL_W'($urandom_range(0, 7));
                default: row.value = {$urandom, $urandom};
            endcase
            // Positions: mostly around the valid range, sometimes anything the field holds.
            pos_sel = $urandom_range(0, 9);
            if (pos_sel < 6) begin
                row.pos = POS_W'($urandom_range(0, 2 * n + 2) - (n + 1));
            end else if (pos_sel < 9) begin
                row.pos = POS_W'($urandom_range(0, 32) - 16);
            end else begin
                row.pos = POS_W'($urandom);
            end
            send_op(row);
        end
        i_s_axis_tvalid = 1'b0;

        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- indexed_queue_store_unit.f -----
rtl/iqs_pkg.sv
rtl/iqs_store.sv
rtl/indexed_queue_store_unit.sv
tb/sv/indexed_queue_store_unit_tb.sv
